// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL of the topic resampler.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: hw/rtl/ldagr_pkg.sv
// Package of the topic resampler: sizes, register indexes, state type and
// saturating count helpers. No dependencies.
`default_nettype none

package ldagr_pkg;

	localparam int NUM_TOPICS = 64;
	localparam int TOPIC_W    = 6;
	localparam int WORD_W     = 12;
	localparam int DOC_W      = 12;
	localparam int COUNT_W    = 24;
	localparam int TOTAL_W    = 32;
	localparam int WEIGHT_W   = 32;
	localparam int RAND_W     = 32;
	localparam int FRAC_W     = 16;
	localparam int PRIOR_W    = 24;
	localparam int VOCAB_W    = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int TAB_ADDR_W = TOPIC_W + WORD_W;
	localparam int TAB_DEPTH  = NUM_TOPICS * (2 ** WORD_W);
	localparam int PROD_W     = 2 * (COUNT_W + FRAC_W);
	localparam int DIVISOR_W  = TOTAL_W + FRAC_W + 1;
	localparam int SUM_W      = WEIGHT_W + TOPIC_W;

	localparam logic [9:0] HUNDREDTH = 10'd655;

	localparam logic [TOPIC_W-1:0]   TOPIC_LAST = TOPIC_W'(NUM_TOPICS - 1);
	localparam logic [PRIOR_W-1:0]   DOC_PRIOR_RST = 24'd3277;
	localparam logic [VOCAB_W-1:0]   VOCAB_RST = 13'd4096;

	localparam logic [CFG_IDX_W-1:0] CFG_DOC_PRIOR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VOCAB     = 1'd1;

	localparam logic [0:0] OP_LOAD     = 1'b0;
	localparam logic [0:0] OP_RESAMPLE = 1'b1;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DROP_RD,
		ST_DROP_WR,
		ST_W_RD,
		ST_W_MUL1,
		ST_W_MUL2,
		ST_W_MUL3,
		ST_W_DSTART,
		ST_W_DIV,
		ST_W_ACC,
		ST_U_MUL,
		ST_U_SUM,
		ST_SEL_RD,
		ST_SEL_EV,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_FIN
	} state_t;

	function automatic logic [COUNT_W-1:0] cnt_inc(input logic [COUNT_W-1:0] x);
		cnt_inc = (x == '1) ? x : x + COUNT_W'(1);
	endfunction

	function automatic logic [COUNT_W-1:0] cnt_dec(input logic [COUNT_W-1:0] x);
		cnt_dec = (x == '0) ? x : x - COUNT_W'(1);
	endfunction

	function automatic logic [TOTAL_W-1:0] tot_inc(input logic [TOTAL_W-1:0] x);
		tot_inc = (x == '1) ? x : x + TOTAL_W'(1);
	endfunction

	function automatic logic [TOTAL_W-1:0] tot_dec(input logic [TOTAL_W-1:0] x);
		tot_dec = (x == '0) ? x : x - TOTAL_W'(1);
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ldagr_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module ldagr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// File: hw/rtl/ldagr_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturated to 32 bits.
// Depends on ldagr_pkg.
`default_nettype none

module ldagr_div (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic [ldagr_pkg::PROD_W-1:0]         dividend,
	input  wire logic [ldagr_pkg::DIVISOR_W-1:0]      divisor,
	output logic                                      done,
	output logic      [ldagr_pkg::WEIGHT_W-1:0]       quotient
);

	localparam int QW = ldagr_pkg::WEIGHT_W;
	localparam int DW = ldagr_pkg::DIVISOR_W;
	localparam int CW = $clog2(QW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;
	logic [QW-1:0] low_q;
	logic [QW-1:0] quot_q;
	logic [DW:0]   trial;
	logic          ge;
	logic          sat;

	assign sat   = {1'b0, dividend[ldagr_pkg::PROD_W-1:QW]} >= divisor;
	assign trial = {rem_q, low_q[QW-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !sat;
			done_q <= sat;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(QW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= DW'(dividend[ldagr_pkg::PROD_W-1:QW]);
			low_q  <= dividend[QW-1:0];
			div_q  <= divisor;
			quot_q <= sat ? '1 : '0;
		end else if (busy_q) begin
			rem_q  <= ge ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
			low_q  <= {low_q[QW-2:0], 1'b0};
			quot_q <= {quot_q[QW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

`default_nettype wire

// File: hw/rtl/lda_gibbs_topic_resampler_unit.sv
// Top level of the LDA collapsed Gibbs topic resampler.
// Depends on ldagr_pkg, ldagr_ram, ldagr_div and assert_macros.svh.
`default_nettype none

// After reset the block sweeps the word-topic, document-topic and topic total
// memories to zero, one entry a cycle; inputs stall during the sweep. A load
// transfer adds one to the counts of its topic. A resample removes the token
// from the counts of its current topic, forms the weight of each topic with
// the bit-serial divider (saturating when the quotient overflows) and then
// picks the new topic by a cumulative scan of the weight memory. One item is
// in work at a time; the result register frees the input side while a
// result waits.
module lda_gibbs_topic_resampler_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [0:0]                            opcode,
	input  wire logic [ldagr_pkg::WORD_W-1:0]          word_index,
	input  wire logic [ldagr_pkg::DOC_W-1:0]           doc_index,
	input  wire logic [ldagr_pkg::TOPIC_W-1:0]         current_topic,
	input  wire logic [ldagr_pkg::RAND_W-1:0]          random_fraction,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic      [ldagr_pkg::TOPIC_W-1:0]         new_topic,
	input  wire logic                                  cfg_we,
	input  wire logic [ldagr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [ldagr_pkg::PRIOR_W-1:0]         cfg_data
);

	localparam int TW = ldagr_pkg::TOPIC_W;
	localparam int CW = ldagr_pkg::COUNT_W;
	localparam int OW = ldagr_pkg::TOTAL_W;
	localparam int AW = ldagr_pkg::TAB_ADDR_W;
	localparam int SW = ldagr_pkg::SUM_W;
	localparam int WW = ldagr_pkg::WEIGHT_W;
	localparam int PW = ldagr_pkg::PROD_W;
	localparam int NW = ldagr_pkg::DIVISOR_W;

	ldagr_pkg::state_t state_q, state_n;

	logic [ldagr_pkg::PRIOR_W-1:0] prior_q;
	logic [ldagr_pkg::VOCAB_W-1:0] vocab_q;
	logic [ldagr_pkg::VOCAB_W-1:0] vocab_eff;
	logic [22:0]                   smooth;

	logic [AW-1:0] clr_q;
	logic          op_q;
	logic [ldagr_pkg::WORD_W-1:0] w_q;
	logic [ldagr_pkg::DOC_W-1:0]  d_q;
	logic [TW-1:0] t_q;
	logic [TW-1:0] k_q;
	logic [TW-1:0] at_q;
	logic [ldagr_pkg::RAND_W-1:0] r_q;
	logic [CW-1:0] wtc_q;
	logic [CW-1:0] dtc_q;
	logic [NW-1:0] n_q;
	logic [2*CW-1:0] prod_hi_q;
	logic [2*CW:0]   prod_mid_q;
	logic [PW-1:0]   prod_q;
	logic [SW-1:0]   z_q;
	logic [63:0]     ulo_q;
	logic [SW-1:0]   uhi_q;
	logic [SW-1:0]   u_q;
	logic [SW-1:0]   cum_q;
	logic [SW-1:0]   cum_n;
	logic            out_valid_q;
	logic [TW-1:0]   new_topic_q;
	logic            fin_go;

	logic          tab_we;
	logic          tot_we;
	logic          wgt_we;
	logic [TW-1:0] topic;
	logic [AW-1:0] wt_addr;
	logic [AW-1:0] dt_addr;
	logic [TW-1:0] tot_addr;
	logic [TW-1:0] wgt_addr;
	logic [CW-1:0] wt_wdata;
	logic [CW-1:0] dt_wdata;
	logic [OW-1:0] tot_wdata;
	logic [CW-1:0] wt_rdata;
	logic [CW-1:0] dt_rdata;
	logic [OW-1:0] tot_rdata;
	logic [WW-1:0] wgt_rdata;
	logic          div_start;
	logic          div_done;
	logic [WW-1:0] div_q;

	assign vocab_eff = (vocab_q == '0) ? ldagr_pkg::VOCAB_W'(1) : vocab_q;
	assign smooth    = 23'(ldagr_pkg::HUNDREDTH) * 23'(vocab_eff);
	assign cum_n     = cum_q + SW'(wgt_rdata);
	assign fin_go    = !out_valid_q || !out_stall;

	ldagr_ram #(.WIDTH(CW), .DEPTH(ldagr_pkg::TAB_DEPTH)) u_wt_ram (
		.clk(clk), .we(tab_we), .addr(wt_addr), .wdata(wt_wdata), .rdata(wt_rdata)
	);

	ldagr_ram #(.WIDTH(CW), .DEPTH(ldagr_pkg::TAB_DEPTH)) u_dt_ram (
		.clk(clk), .we(tab_we), .addr(dt_addr), .wdata(dt_wdata), .rdata(dt_rdata)
	);

	ldagr_ram #(.WIDTH(OW), .DEPTH(ldagr_pkg::NUM_TOPICS)) u_tot_ram (
		.clk(clk), .we(tot_we), .addr(tot_addr), .wdata(tot_wdata), .rdata(tot_rdata)
	);

	ldagr_ram #(.WIDTH(WW), .DEPTH(ldagr_pkg::NUM_TOPICS)) u_wgt_ram (
		.clk(clk), .we(wgt_we), .addr(wgt_addr), .wdata(div_q), .rdata(wgt_rdata)
	);

	ldagr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(prod_q),
		.divisor(n_q), .done(div_done), .quotient(div_q)
	);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ldagr_pkg::ST_CLEAR: begin
				if (clr_q == '1) state_n = ldagr_pkg::ST_IDLE;
			end
			ldagr_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_n = (opcode == ldagr_pkg::OP_RESAMPLE) ? ldagr_pkg::ST_DROP_RD
						: ldagr_pkg::ST_ADD_RD;
				end
			end
			ldagr_pkg::ST_DROP_RD:  state_n = ldagr_pkg::ST_DROP_WR;
			ldagr_pkg::ST_DROP_WR:  state_n = ldagr_pkg::ST_W_RD;
			ldagr_pkg::ST_W_RD:     state_n = ldagr_pkg::ST_W_MUL1;
			ldagr_pkg::ST_W_MUL1:   state_n = ldagr_pkg::ST_W_MUL2;
			ldagr_pkg::ST_W_MUL2:   state_n = ldagr_pkg::ST_W_MUL3;
			ldagr_pkg::ST_W_MUL3:   state_n = ldagr_pkg::ST_W_DSTART;
			ldagr_pkg::ST_W_DSTART: state_n = ldagr_pkg::ST_W_DIV;
			ldagr_pkg::ST_W_DIV: begin
				if (div_done) state_n = ldagr_pkg::ST_W_ACC;
			end
			ldagr_pkg::ST_W_ACC: begin
				state_n = (k_q == ldagr_pkg::TOPIC_LAST) ? ldagr_pkg::ST_U_MUL
					: ldagr_pkg::ST_W_RD;
			end
			ldagr_pkg::ST_U_MUL:    state_n = ldagr_pkg::ST_U_SUM;
			ldagr_pkg::ST_U_SUM:    state_n = ldagr_pkg::ST_SEL_RD;
			ldagr_pkg::ST_SEL_RD:   state_n = ldagr_pkg::ST_SEL_EV;
			ldagr_pkg::ST_SEL_EV: begin
				if (u_q <= cum_n || k_q == ldagr_pkg::TOPIC_LAST) begin
					state_n = ldagr_pkg::ST_ADD_RD;
				end else begin
					state_n = ldagr_pkg::ST_SEL_RD;
				end
			end
			ldagr_pkg::ST_ADD_RD:   state_n = ldagr_pkg::ST_ADD_WR;
			ldagr_pkg::ST_ADD_WR:   state_n = ldagr_pkg::ST_FIN;
			ldagr_pkg::ST_FIN: begin
				if (fin_go) state_n = ldagr_pkg::ST_IDLE;
			end
			default:                state_n = ldagr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		tab_we    = 1'b0;
		tot_we    = 1'b0;
		wgt_we    = 1'b0;
		div_start = 1'b0;
		topic     = k_q;
		wt_wdata  = '0;
		dt_wdata  = '0;
		tot_wdata = '0;
		wgt_addr  = k_q;
		unique case (state_q)
			ldagr_pkg::ST_CLEAR: begin
				tab_we = 1'b1;
				tot_we = 1'b1;
			end
			ldagr_pkg::ST_DROP_RD: topic = t_q;
			ldagr_pkg::ST_DROP_WR: begin
				topic     = t_q;
				tab_we    = 1'b1;
				tot_we    = 1'b1;
				wt_wdata  = ldagr_pkg::cnt_dec(wt_rdata);
				dt_wdata  = ldagr_pkg::cnt_dec(dt_rdata);
				tot_wdata = ldagr_pkg::tot_dec(tot_rdata);
			end
			ldagr_pkg::ST_W_DSTART: div_start = 1'b1;
			ldagr_pkg::ST_W_ACC:    wgt_we = 1'b1;
			ldagr_pkg::ST_ADD_RD:   topic = at_q;
			ldagr_pkg::ST_ADD_WR: begin
				topic     = at_q;
				tab_we    = 1'b1;
				tot_we    = 1'b1;
				wt_wdata  = ldagr_pkg::cnt_inc(wt_rdata);
				dt_wdata  = ldagr_pkg::cnt_inc(dt_rdata);
				tot_wdata = ldagr_pkg::tot_inc(tot_rdata);
			end
			default: ;
		endcase
		if (state_q == ldagr_pkg::ST_CLEAR) begin
			wt_addr  = clr_q;
			dt_addr  = clr_q;
			tot_addr = clr_q[TW-1:0];
		end else begin
			wt_addr  = {topic, w_q};
			dt_addr  = {topic, d_q};
			tot_addr = topic;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ldagr_pkg::ST_CLEAR;
			clr_q       <= '0;
			prior_q     <= ldagr_pkg::DOC_PRIOR_RST;
			vocab_q     <= ldagr_pkg::VOCAB_RST;
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == ldagr_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (cfg_we) begin
				unique case (cfg_index)
					ldagr_pkg::CFG_DOC_PRIOR: prior_q <= cfg_data;
					ldagr_pkg::CFG_VOCAB:     vocab_q <= cfg_data[ldagr_pkg::VOCAB_W-1:0];
					default: ;
				endcase
			end
			if (state_q == ldagr_pkg::ST_FIN && fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ldagr_pkg::ST_IDLE:  k_q <= '0;
				ldagr_pkg::ST_W_ACC: k_q <= k_q + TW'(1);
				ldagr_pkg::ST_U_SUM: k_q <= '0;
				ldagr_pkg::ST_SEL_EV: begin
					if (!(u_q <= cum_n || k_q == ldagr_pkg::TOPIC_LAST)) k_q <= k_q + TW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ldagr_pkg::ST_IDLE: begin
				op_q <= opcode[0];
				w_q  <= word_index;
				d_q  <= doc_index;
				t_q  <= current_topic;
				at_q <= current_topic;
				r_q  <= random_fraction;
				z_q  <= '0;
			end
			ldagr_pkg::ST_W_MUL1: begin
				wtc_q     <= wt_rdata;
				dtc_q     <= dt_rdata;
				n_q       <= {1'b0, tot_rdata, {ldagr_pkg::FRAC_W{1'b0}}} + NW'(smooth);
				prod_hi_q <= (2*CW)'(wt_rdata) * (2*CW)'(dt_rdata);
			end
			ldagr_pkg::ST_W_MUL2: begin
				prod_mid_q <= (2*CW+1)'((2*CW)'(wtc_q) * (2*CW)'(prior_q))
					+ (2*CW+1)'((2*CW)'(ldagr_pkg::HUNDREDTH) * (2*CW)'(dtc_q));
			end
			ldagr_pkg::ST_W_MUL3: begin
				prod_q <= {prod_hi_q, 32'b0} + PW'({prod_mid_q, 16'b0})
					+ PW'(34'(ldagr_pkg::HUNDREDTH) * 34'(prior_q));
			end
			ldagr_pkg::ST_W_ACC: z_q <= z_q + SW'(div_q);
			ldagr_pkg::ST_U_MUL: begin
				ulo_q <= 64'(z_q[31:0]) * 64'(r_q);
				uhi_q <= SW'(z_q[SW-1:32]) * SW'(r_q);
			end
			ldagr_pkg::ST_U_SUM: begin
				u_q   <= uhi_q + SW'(ulo_q[63:32]);
				cum_q <= '0;
			end
			ldagr_pkg::ST_SEL_EV: begin
				cum_q <= cum_n;
				if (u_q <= cum_n || k_q == ldagr_pkg::TOPIC_LAST) at_q <= k_q;
			end
			ldagr_pkg::ST_FIN: begin
				if (fin_go) new_topic_q <= at_q;
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != ldagr_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign new_topic = new_topic_q;

	`include "assert_macros.svh"

	`ASSERT_AT(a_div_done_in_wait, clk, arst_n,
		div_done |-> (state_q == ldagr_pkg::ST_W_DIV), "divider finished outside wait")
	`ASSERT_AT(a_add_wr_after_rd, clk, arst_n,
		(state_q == ldagr_pkg::ST_ADD_WR) |-> ($past(state_q) == ldagr_pkg::ST_ADD_RD),
		"count increment without read")
	`ASSERT_NEVER(a_no_result_in_clear, clk, arst_n,
		(state_q == ldagr_pkg::ST_CLEAR) && out_valid_q, "result during clearing sweep")
	`ASSERT_AT(a_resample_op, clk, arst_n,
		(state_q == ldagr_pkg::ST_DROP_WR) |-> (op_q == ldagr_pkg::OP_RESAMPLE),
		"removal on a load transfer")

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench of the LDA Gibbs topic resampler: random and directed
// load/resample transfers predicted by an in-bench count-table model.
// Depends on ldagr_pkg and lda_gibbs_topic_resampler_unit.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 1200000;
	localparam int POOL_N      = 48;

	typedef struct {
		bit                                 op;
		logic [ldagr_pkg::WORD_W-1:0]       word;
		logic [ldagr_pkg::DOC_W-1:0]        doc;
		logic [ldagr_pkg::TOPIC_W-1:0]      topic;
		logic [ldagr_pkg::RAND_W-1:0]       frac;
		int                                 id;
	} token_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [0:0] opcode;
	logic [ldagr_pkg::WORD_W-1:0] word_index;
	logic [ldagr_pkg::DOC_W-1:0] doc_index;
	logic [ldagr_pkg::TOPIC_W-1:0] current_topic;
	logic [ldagr_pkg::RAND_W-1:0] random_fraction;
	logic [ldagr_pkg::TOPIC_W-1:0] new_topic;
	logic cfg_we;
	logic [ldagr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ldagr_pkg::PRIOR_W-1:0] cfg_data;

	token_t pending_tokens[$];
	token_t cur_token;
	logic [ldagr_pkg::TOPIC_W-1:0] topic_expect_q[$];

	logic [ldagr_pkg::COUNT_W-1:0] word_topic_cnt[int];
	logic [ldagr_pkg::COUNT_W-1:0] doc_topic_cnt[int];
	logic [ldagr_pkg::TOTAL_W-1:0] topic_total[ldagr_pkg::NUM_TOPICS];
	logic [ldagr_pkg::PRIOR_W-1:0] doc_prior_sh;
	logic [ldagr_pkg::VOCAB_W-1:0] vocab_sh;

	logic [ldagr_pkg::WORD_W-1:0] pool_word[POOL_N];
	logic [ldagr_pkg::DOC_W-1:0] pool_doc[POOL_N];
	logic [ldagr_pkg::TOPIC_W-1:0] pool_topic[POOL_N];

	int accepted_in, accepted_out, idle_cycles, hold_left;
	bit failed;

	lda_gibbs_topic_resampler_unit DUT (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic bit steady();
		return accepted_in >= 900 && accepted_in < 1100;
	endfunction

	function automatic int wt_key(logic [ldagr_pkg::TOPIC_W-1:0] t,
			logic [ldagr_pkg::WORD_W-1:0] w);
		return int'({t, w});
	endfunction

	function automatic int dt_key(logic [ldagr_pkg::TOPIC_W-1:0] t,
			logic [ldagr_pkg::DOC_W-1:0] d);
		return int'({t, d});
	endfunction

	task automatic count_add(logic [ldagr_pkg::TOPIC_W-1:0] t,
			logic [ldagr_pkg::WORD_W-1:0] w, logic [ldagr_pkg::DOC_W-1:0] d);
		logic [ldagr_pkg::COUNT_W-1:0] c;
		if (topic_total[t] != '1) topic_total[t]++;
		c = word_topic_cnt.exists(wt_key(t, w)) ? word_topic_cnt[wt_key(t, w)] : '0;
		word_topic_cnt[wt_key(t, w)] = (c == '1) ? c : c + 1'b1;
		c = doc_topic_cnt.exists(dt_key(t, d)) ? doc_topic_cnt[dt_key(t, d)] : '0;
		doc_topic_cnt[dt_key(t, d)] = (c == '1) ? c : c + 1'b1;
	endtask

	task automatic count_remove(logic [ldagr_pkg::TOPIC_W-1:0] t,
			logic [ldagr_pkg::WORD_W-1:0] w, logic [ldagr_pkg::DOC_W-1:0] d);
		if (topic_total[t] != '0) topic_total[t]--;
		if (word_topic_cnt.exists(wt_key(t, w)) && word_topic_cnt[wt_key(t, w)] != '0)
			word_topic_cnt[wt_key(t, w)]--;
		if (doc_topic_cnt.exists(dt_key(t, d)) && doc_topic_cnt[dt_key(t, d)] != '0)
			doc_topic_cnt[dt_key(t, d)]--;
	endtask

	task automatic sample_topic(input token_t tk,
			output logic [ldagr_pkg::TOPIC_W-1:0] pick);
		logic [31:0] weight[ldagr_pkg::NUM_TOPICS];
		logic [63:0] a, b, n, vocab;
		logic [127:0] q, z, u, cum;
		logic [ldagr_pkg::COUNT_W-1:0] wc, dc;
		logic [ldagr_pkg::TOPIC_W-1:0] kt;
		int k;
		if (tk.op == ldagr_pkg::OP_LOAD) begin
			count_add(tk.topic, tk.word, tk.doc);
			pick = tk.topic;
			return;
		end
		count_remove(tk.topic, tk.word, tk.doc);
		vocab = (vocab_sh == 0) ? 64'd1 : 64'(vocab_sh);
		z = 0;
		for (k = 0; k < ldagr_pkg::NUM_TOPICS; k++) begin
			kt = ldagr_pkg::TOPIC_W'(k);
			wc = word_topic_cnt.exists(wt_key(kt, tk.word)) ?
				word_topic_cnt[wt_key(kt, tk.word)] : '0;
			dc = doc_topic_cnt.exists(dt_key(kt, tk.doc)) ?
				doc_topic_cnt[dt_key(kt, tk.doc)] : '0;
			a = (64'(wc) << 16) + 64'(ldagr_pkg::HUNDREDTH);
			b = (64'(dc) << 16) + 64'(doc_prior_sh);
			n = (64'(topic_total[k]) << 16) + 64'(ldagr_pkg::HUNDREDTH) * vocab;
			q = (128'(a) * 128'(b)) / 128'(n);
			weight[k] = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
			z += 128'(weight[k]);
		end
		u = (z * 128'(tk.frac)) >> 32;
		k = 0;
		cum = 128'(weight[0]);
		while (u > cum && k < ldagr_pkg::NUM_TOPICS - 1) begin
			k++;
			cum += 128'(weight[k]);
		end
		count_add(ldagr_pkg::TOPIC_W'(k), tk.word, tk.doc);
		pick = ldagr_pkg::TOPIC_W'(k);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		logic [ldagr_pkg::TOPIC_W-1:0] pick;
		token_t nxt;
		bit have;
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= '0;
			word_index <= '0;
			doc_index <= '0;
			current_topic <= '0;
			random_fraction <= '0;
		end else begin
			have = in_valid;
			if (in_valid && !in_stall) begin
				sample_topic(cur_token, pick);
				topic_expect_q.push_back(pick);
				if (cur_token.id >= 0) pool_topic[cur_token.id] = pick;
				accepted_in++;
				have = 0;
			end
			if (!have) begin
				if (pending_tokens.size() > 0 && (steady() || $urandom_range(99) >= 11)) begin
					nxt = pending_tokens.pop_front();
					if (nxt.id >= 0) begin
						nxt.word = pool_word[nxt.id];
						nxt.doc = pool_doc[nxt.id];
						if (nxt.op == ldagr_pkg::OP_RESAMPLE) nxt.topic = pool_topic[nxt.id];
					end
					cur_token = nxt;
					in_valid <= 1'b1;
					opcode <= nxt.op;
					word_index <= nxt.word;
					doc_index <= nxt.doc;
					current_topic <= nxt.topic;
					random_fraction <= nxt.frac;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		logic [ldagr_pkg::TOPIC_W-1:0] want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				accepted_out++;
				if (topic_expect_q.size() == 0) begin
					$error("unexpected transfer, new_topic %0d", new_topic);
					failed = 1;
				end else begin
					want = topic_expect_q.pop_front();
					if (new_topic !== want) begin
						$error("new_topic expected %0d actual %0d", want, new_topic);
						failed = 1;
					end
				end
				if (accepted_out == 100) hold_left = 6000;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !steady() && $urandom_range(99) < 11;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	task automatic write_cfg(logic [ldagr_pkg::PRIOR_W-1:0] prior,
			logic [ldagr_pkg::PRIOR_W-1:0] vocab);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ldagr_pkg::CFG_DOC_PRIOR;
		cfg_data <= prior;
		doc_prior_sh = prior;
		@(posedge clk);
		cfg_index <= ldagr_pkg::CFG_VOCAB;
		cfg_data <= vocab;
		vocab_sh = vocab[ldagr_pkg::VOCAB_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push(bit op, logic [ldagr_pkg::WORD_W-1:0] w,
			logic [ldagr_pkg::DOC_W-1:0] d, logic [ldagr_pkg::TOPIC_W-1:0] t,
			logic [ldagr_pkg::RAND_W-1:0] r, int id);
		token_t tk;
		tk = '{op: op, word: w, doc: d, topic: t, frac: r, id: id};
		pending_tokens.push_back(tk);
	endtask

	task automatic fill_random(int num);
		int id;
		repeat (num) begin
			id = $urandom_range(POOL_N - 1);
			case ($urandom_range(9))
				0, 1, 2: push(ldagr_pkg::OP_LOAD, '0, '0, ldagr_pkg::TOPIC_W'($urandom),
					ldagr_pkg::RAND_W'($urandom), id);
				3, 4, 5, 6: push(ldagr_pkg::OP_RESAMPLE, '0, '0, '0,
					ldagr_pkg::RAND_W'($urandom), id);
				7: push(ldagr_pkg::OP_LOAD, ldagr_pkg::WORD_W'($urandom),
					ldagr_pkg::DOC_W'($urandom), ldagr_pkg::TOPIC_W'($urandom),
					ldagr_pkg::RAND_W'($urandom), -1);
				default: push(ldagr_pkg::OP_RESAMPLE, ldagr_pkg::WORD_W'($urandom),
					ldagr_pkg::DOC_W'($urandom), ldagr_pkg::TOPIC_W'($urandom),
					ldagr_pkg::RAND_W'($urandom), -1);
			endcase
		end
	endtask

	task automatic drain();
		wait (pending_tokens.size() == 0 && !in_valid && topic_expect_q.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		accepted_in = 0;
		accepted_out = 0;
		idle_cycles = 0;
		failed = 0;
		doc_prior_sh = ldagr_pkg::DOC_PRIOR_RST;
		vocab_sh = ldagr_pkg::VOCAB_RST;
		for (int i = 0; i < ldagr_pkg::NUM_TOPICS; i++) topic_total[i] = '0;
		for (int i = 0; i < POOL_N; i++) begin
			pool_word[i] = ldagr_pkg::WORD_W'($urandom_range(7));
			pool_doc[i] = (i < 4) ? ldagr_pkg::DOC_W'(4095 - i)
				: ldagr_pkg::DOC_W'($urandom_range(5));
			pool_topic[i] = '0;
		end
		pool_word[0] = '1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		write_cfg(24'd3277, 24'd4096);

		// directed: field extremes, underflow, zero weights, both random ends
		push(ldagr_pkg::OP_RESAMPLE, 12'd5, 12'd9, 6'd3, 32'h0, -1);
		push(ldagr_pkg::OP_LOAD, 12'h000, 12'h000, 6'd0, 32'h0, -1);
		push(ldagr_pkg::OP_LOAD, 12'hFFF, 12'hFFF, 6'h3F, 32'hFFFF_FFFF, -1);
		push(ldagr_pkg::OP_LOAD, 12'hFFF, 12'h000, 6'h2A, 32'h5555_5555, -1);
		push(ldagr_pkg::OP_LOAD, 12'h000, 12'hFFF, 6'h15, 32'hAAAA_AAAA, -1);
		push(ldagr_pkg::OP_RESAMPLE, 12'hFFF, 12'hFFF, 6'h3F, 32'hFFFF_FFFF, -1);
		push(ldagr_pkg::OP_RESAMPLE, 12'h000, 12'h000, 6'd0, 32'h0, -1);
		push(ldagr_pkg::OP_RESAMPLE, 12'hFFF, 12'h000, 6'h2A, 32'hFFFF_FFFF, -1);
		push(ldagr_pkg::OP_RESAMPLE, 12'h000, 12'hFFF, 6'h15, 32'h8000_0000, -1);
		for (int i = 0; i < 6; i++)
			push(ldagr_pkg::OP_LOAD, '0, '0, ldagr_pkg::TOPIC_W'(i * 11),
				ldagr_pkg::RAND_W'($urandom), i);
		for (int i = 0; i < 6; i++)
			push(ldagr_pkg::OP_RESAMPLE, '0, '0, '0, (i % 2) ? '1 : '0, i);
		drain();

		fill_random(450);
		drain();
		write_cfg(24'd0, 24'd0);
		push(ldagr_pkg::OP_RESAMPLE, 12'd4000, 12'd4000, 6'd7, 32'hFFFF_FFFF, -1);
		fill_random(400);
		drain();
		write_cfg(24'hFFFFFF, 24'hFFF000);
		fill_random(400);
		drain();
		write_cfg(ldagr_pkg::PRIOR_W'($urandom), 24'd1);
		fill_random(480);
		drain();
		repeat (3000) @(posedge clk);
		if (!failed)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule

// File: lda_gibbs_topic_resampler_unit.f
+incdir+hw/rtl
hw/rtl/ldagr_pkg.sv
hw/rtl/ldagr_ram.sv
hw/rtl/ldagr_div.sv
hw/rtl/lda_gibbs_topic_resampler_unit.sv
dv/testbench.sv
